/* design/stga_pkg.sv */
package stga_pkg;
  localparam int MAX_STATIONS_DEF = 256;
  localparam int GRID_SIDE_DEF = 1024;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LON = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LAT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LON_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_STEP = 3'd5;

  typedef struct packed {
    logic load;
    logic eval_init;
    logic rd_issue;
    logic delta;
    logic sq;
    logic wstart;
    logic accum;
    logic div_start;
  } stga_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic mean_done;
  } stga_sts_t;
endpackage

/* design/stga_datapath.sv */
module stga_datapath import stga_pkg::*; #(
  parameter int MAX_STATIONS = MAX_STATIONS_DEF,
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  stga_cmd_t          cmd,
  output stga_sts_t          sts,
  input  logic               restart,
  input  logic signed [31:0] station_lon,
  input  logic signed [31:0] station_lat,
  input  logic signed [31:0] sample_first,
  input  logic signed [31:0] sample_second,
  input  logic [9:0]         row_index,
  input  logic [9:0]         col_index,
  input  logic               vector_mode,
  input  logic [30:0]        radius,
  input  logic signed [31:0] origin_lon,
  input  logic signed [31:0] origin_lat,
  input  logic signed [31:0] lon_step,
  input  logic signed [31:0] lat_step,
  output logic signed [31:0] grid_first,
  output logic signed [31:0] grid_second,
  output logic [8:0]         hits,
  output logic               no_coverage,
  output logic               stations_dropped
);
  localparam int AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam int CW = $clog2(MAX_STATIONS + 1);
  localparam int GW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int SW = 17 + CW;
  localparam int SVW = 49 + CW;

  logic [127:0] mem [MAX_STATIONS];
  logic [127:0] rd;
  logic [CW-1:0] count;
  logic dropped;
  logic [CW-1:0] scan;
  logic [CW-1:0] cnt_eff;
  logic scan_done, div_done, mean_done;

  assign cnt_eff = restart ? '0 : count;

  always_ff @(posedge clk) begin
    if (cmd.load && cnt_eff < CW'(MAX_STATIONS))
      mem[cnt_eff[AW-1:0]] <= {station_lon, station_lat, sample_first, sample_second};
    if (cmd.rd_issue)
      rd <= mem[scan[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (cnt_eff < CW'(MAX_STATIONS)) begin
        count <= cnt_eff + 1'b1;
        dropped <= restart ? 1'b0 : dropped;
      end else begin
        count <= cnt_eff;
        dropped <= 1'b1;
      end
    end
  end

  // grid point, row and column saturated
  logic [GW-1:0] rowc, colc;
  always_comb begin
    rowc = (32'(row_index) >= 32'(GRID_SIDE)) ? GW'(GRID_SIDE - 1) : GW'(row_index);
    colc = (32'(col_index) >= 32'(GRID_SIDE)) ? GW'(GRID_SIDE - 1) : GW'(col_index);
  end

  logic signed [33+GW:0] gx, gy;
  logic [61:0] r2;
  logic vec;
  logic signed [34+GW:0] dx, dy;
  logic [33+GW:0] ax, ay;
  logic [61:0] sqx, sqy;
  logic [63:0] d2;
  logic ok;
  logic signed [31:0] v1, v2;

  always_comb begin
    dx = (35+GW)'(gx) - (35+GW)'(signed'(rd[127:96]));
    dy = (35+GW)'(gy) - (35+GW)'(signed'(rd[95:64]));
    sqx = ax[30:0] * ax[30:0];
    sqy = ay[30:0] * ay[30:0];
  end

  // divider
  logic [48:0] dnum;
  logic [63:0] drem;
  logic [31:0] dden;
  logic [16:0] dq;
  logic [5:0]  dcnt;
  logic dbusy;
  logic [63:0] den_full;
  logic [5:0]  den_msb, sh;

  // normalising shift: den below 2^32
  always_comb begin
    den_full = 64'(r2) + d2;
    den_msb = '0;
    for (int i = 0; i < 64; i++)
      if (den_full[i]) den_msb = 6'(i);
    sh = (den_msb > 6'd31) ? den_msb - 6'd31 : 6'd0;
  end

  logic signed [SW-1:0]  sum_w;
  logic signed [SVW-1:0] sum_a, sum_b;
  logic signed [49:0] pa, pb;
  logic [CW-1:0] hitc;

  always_comb begin
    pa = v1 * signed'({1'b0, dq});
    pb = v2 * signed'({1'b0, dq});
  end

  // mean division, restoring, on magnitudes
  logic [SVW-1:0] ma, mb, ra, rb, qa, qb;
  logic na, nb;
  logic [6:0] mcnt;
  logic mbusy;
  logic [SVW:0] ta, tb;

  always_comb begin
    ta = {ra, ma[SVW-1]} - (SVW+1)'(unsigned'(sum_w));
    tb = {rb, mb[SVW-1]} - (SVW+1)'(unsigned'(sum_w));
  end

  logic [64:0] dt;
  assign dt = {drem, dnum[48]} - 65'(dden);

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      mbusy <= 1'b0;
      scan_done <= 1'b0;
      div_done <= 1'b0;
      mean_done <= 1'b0;
      scan <= '0;
    end else begin
      div_done <= 1'b0;
      mean_done <= 1'b0;
      if (cmd.eval_init) begin
        scan <= '0;
        scan_done <= (count == '0);
      end
      if (cmd.rd_issue) begin
        scan <= scan + 1'b1;
        scan_done <= (scan + 1'b1 >= count);
      end
      if (cmd.wstart) dbusy <= 1'b1;
      if (dbusy) begin
        if (dcnt == 6'd48) begin
          dbusy <= 1'b0;
          div_done <= 1'b1;
        end
      end
      if (cmd.div_start) mbusy <= 1'b1;
      if (mbusy && mcnt == 7'(SVW - 1)) begin
        mbusy <= 1'b0;
        mean_done <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.scan_done = scan_done;
    sts.div_done = div_done;
    sts.mean_done = mean_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_init) begin
      gx <= (34+GW)'(origin_lon) + lon_step * $signed({1'b0, colc});
      gy <= (34+GW)'(origin_lat) + lat_step * $signed({1'b0, rowc});
      r2 <= radius * radius;
      vec <= vector_mode;
      sum_w <= '0;
      sum_a <= '0;
      sum_b <= '0;
      hitc <= '0;
    end
    if (cmd.delta) begin
      ax <= dx[34+GW] ? (34+GW)'(-dx) : (34+GW)'(dx);
      ay <= dy[34+GW] ? (34+GW)'(-dy) : (34+GW)'(dy);
      v1 <= rd[63:32];
      v2 <= rd[31:0];
    end
    if (cmd.sq) begin
      ok <= (ax < (34+GW)'(radius)) && (ay < (34+GW)'(radius));
      d2 <= 64'(sqx) + 64'(sqy);
    end
    if (cmd.wstart) begin
      dden <= 32'(den_full >> sh);
      dnum <= 49'(((64'(r2) - d2) >> sh) << 16);
      drem <= '0;
      dq <= '0;
      dcnt <= '0;
    end
    if (dbusy) begin
      if (!dt[64]) begin
        drem <= dt[63:0];
        dq <= {dq[15:0], 1'b1};
      end else begin
        drem <= {drem[62:0], dnum[48]};
        dq <= {dq[15:0], 1'b0};
      end
      dnum <= {dnum[47:0], 1'b0};
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.accum) begin
      if (ok && d2 < 64'(r2)) begin
        hitc <= hitc + 1'b1;
        sum_w <= sum_w + SW'(signed'({1'b0, dq}));
        sum_b <= sum_b + SVW'(pb);
        if (vec) sum_a <= sum_a + SVW'(pa);
      end
    end
    if (cmd.div_start) begin
      na <= sum_a[SVW-1];
      nb <= sum_b[SVW-1];
      ma <= sum_a[SVW-1] ? -sum_a : sum_a;
      mb <= sum_b[SVW-1] ? -sum_b : sum_b;
      ra <= '0;
      rb <= '0;
      qa <= '0;
      qb <= '0;
      mcnt <= '0;
    end
    if (mbusy) begin
      if (!ta[SVW]) begin ra <= ta[SVW-1:0]; qa <= {qa[SVW-2:0], 1'b1}; end
      else begin ra <= {ra[SVW-2:0], ma[SVW-1]}; qa <= {qa[SVW-2:0], 1'b0}; end
      if (!tb[SVW]) begin rb <= tb[SVW-1:0]; qb <= {qb[SVW-2:0], 1'b1}; end
      else begin rb <= {rb[SVW-2:0], mb[SVW-1]}; qb <= {qb[SVW-2:0], 1'b0}; end
      ma <= {ma[SVW-2:0], 1'b0};
      mb <= {mb[SVW-2:0], 1'b0};
      mcnt <= mcnt + 1'b1;
    end
  end

  always_comb begin
    no_coverage = (sum_w == '0);
    grid_first = (no_coverage || !vec) ? 32'sd0 : (na ? 32'(-qa) : 32'(qa));
    grid_second = no_coverage ? 32'sd0 : (nb ? 32'(-qb) : 32'(qb));
    hits = 9'(hitc);
    stations_dropped = dropped;
  end
endmodule

/* design/stga_ctrl.sv */
module stga_ctrl import stga_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      op,
  input  stga_sts_t sts,
  output stga_cmd_t cmd,
  output logic      busy,
  output logic      done
);
  typedef enum logic [3:0] {
    IDLE, CHECK, READ, DIST, SQ, WGT, WAITD, ACC, MEAN, WAITM, OUT
  } state_t;
  state_t state;

  always_comb begin
    cmd = '0;
    cmd.load = start && !busy && !op;
    // grid point and row, column captured at the transfer itself
    cmd.eval_init = start && !busy && op;
    cmd.rd_issue = (state == READ);
    cmd.delta = (state == DIST);
    cmd.sq = (state == SQ);
    cmd.wstart = (state == WGT);
    cmd.accum = (state == ACC);
    cmd.div_start = (state == MEAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: if (start && op) begin state <= CHECK; busy <= 1'b1; end
        CHECK: state <= sts.scan_done ? MEAN : READ;
        READ: state <= DIST;
        DIST: state <= SQ;
        SQ: state <= WGT;
        WGT: state <= WAITD;
        WAITD: if (sts.div_done) state <= ACC;
        ACC: state <= CHECK;
        MEAN: state <= WAITM;
        WAITM: if (sts.mean_done) state <= OUT;
        OUT: begin state <= IDLE; busy <= 1'b0; done <= 1'b1; end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

/* design/scattered_to_grid_weighted_average_top.sv */
// load: no result, the next item may follow at once
// evaluate: done pulses once all n stored stations are scanned and the means are divided
// per station: check, read, distance, square, weight start, a wait on the shared 49-step weight divider, accumulate
// means come from a 58-step divider (256 entries); next transfer at the end of done
// done lasts one cycle; the receiver cannot stall. synchronous reset empties the table
module scattered_to_grid_weighted_average_top import stga_pkg::*; #(
  parameter int MAX_STATIONS = MAX_STATIONS_DEF,
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic               restart,
  input  logic signed [31:0] station_lon,
  input  logic signed [31:0] station_lat,
  input  logic signed [31:0] sample_first,
  input  logic signed [31:0] sample_second,
  input  logic [9:0]         row_index,
  input  logic [9:0]         col_index,
  output logic               done,
  output logic signed [31:0] grid_first,
  output logic signed [31:0] grid_second,
  output logic [8:0]         hits,
  output logic               no_coverage,
  output logic               stations_dropped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);
  logic vector_mode;
  logic [30:0] radius;
  logic signed [31:0] origin_lon, origin_lat, lon_step, lat_step;
  stga_cmd_t cmd;
  stga_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_mode <= 1'b0;
      radius <= 31'd65536;
      origin_lon <= '0;
      origin_lat <= '0;
      lon_step <= 32'sd3277;
      lat_step <= 32'sd3277;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VECTOR_MODE: vector_mode <= cfg_data[0];
        REG_RADIUS:      radius <= cfg_data[30:0];
        REG_ORIGIN_LON:  origin_lon <= cfg_data;
        REG_ORIGIN_LAT:  origin_lat <= cfg_data;
        REG_LON_STEP:    lon_step <= cfg_data;
        REG_LAT_STEP:    lat_step <= cfg_data;
        default: ;
      endcase
    end
  end

  stga_ctrl u_ctrl (
    .clk, .rst, .start, .op, .sts, .cmd, .busy, .done
  );

  stga_datapath #(.MAX_STATIONS(MAX_STATIONS), .GRID_SIDE(GRID_SIDE)) u_dp (
    .clk, .rst, .cmd, .sts, .restart, .station_lon, .station_lat,
    .sample_first, .sample_second, .row_index, .col_index, .vector_mode,
    .radius, .origin_lon, .origin_lat, .lon_step, .lat_step, .grid_first,
    .grid_second, .hits, .no_coverage, .stations_dropped
  );
endmodule

/* tb/tb_top.sv */
module tb_top import stga_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // small table so the overflow path is reached with few transfers
  localparam int TABLE_DEPTH = 16;
  localparam int GRID_N = GRID_SIDE_DEF;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic        op;
    logic        restart;
    logic [31:0] lon;
    logic [31:0] lat;
    logic [31:0] first;
    logic [31:0] second;
    logic [9:0]  row;
    logic [9:0]  col;
    bit          drain;
  } station_op_t;

  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
    logic [8:0]  hits;
    logic        no_cov;
    logic        dropped;
  } grid_value_t;

  logic clk, rst, busy, done;
  logic start = 1'b0;
  logic op = 1'b0;
  logic restart = 1'b0;
  logic signed [31:0] station_lon = '0, station_lat = '0;
  logic signed [31:0] sample_first = '0, sample_second = '0;
  logic [9:0] row_index = '0, col_index = '0;
  logic signed [31:0] grid_first, grid_second;
  logic [8:0] hits;
  logic no_coverage, stations_dropped;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  scattered_to_grid_weighted_average_top #(.MAX_STATIONS(TABLE_DEPTH)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .restart(restart),
    .station_lon(station_lon), .station_lat(station_lat),
    .sample_first(sample_first), .sample_second(sample_second),
    .row_index(row_index), .col_index(col_index), .done(done),
    .grid_first(grid_first), .grid_second(grid_second), .hits(hits),
    .no_coverage(no_coverage), .stations_dropped(stations_dropped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // analysis state kept alongside the block
  longint st_lon[TABLE_DEPTH], st_lat[TABLE_DEPTH], st_first[TABLE_DEPTH];
  longint st_second[TABLE_DEPTH];
  int unsigned st_count;
  bit st_overflow;
  bit m_vec;
  logic [30:0] m_radius = 31'd65536;
  logic [31:0] m_olon = '0, m_olat = '0, m_lstep = 32'd3277, m_tstep = 32'd3277;

  station_op_t pending_ops[$];
  grid_value_t expected_grid[$];
  int gap;
  bit took;
  int cfg_count;
  int mismatches;
  longint cycles;

  function automatic void queue_op(station_op_t it);
    pending_ops.insert(pending_ops.size(), it);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(20, 90);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic grid_value_t evaluate_point(logic [9:0] row, logic [9:0] col);
    grid_value_t res;
    longint gx, gy, sw, sa, sb, w, ri, ci;
    longint unsigned ax, ay, r, r2, d2, num, den;
    int unsigned hc, sh;
    ri = (row >= GRID_N) ? GRID_N - 1 : longint'(row);
    ci = (col >= GRID_N) ? GRID_N - 1 : longint'(col);
    gx = longint'($signed(m_olon)) + longint'($signed(m_lstep)) * ci;
    gy = longint'($signed(m_olat)) + longint'($signed(m_tstep)) * ri;
    r = longint'(m_radius);
    r2 = r * r;
    sw = 0; sa = 0; sb = 0; hc = 0;
    for (int k = 0; k < st_count; k++) begin
      ax = magnitude(gx - st_lon[k]);
      ay = magnitude(gy - st_lat[k]);
      if (ax >= r || ay >= r) continue;
      d2 = ax * ax + ay * ay;
      if (d2 >= r2) continue;
      hc++;
      num = r2 - d2;
      den = r2 + d2;
      sh = 0;
      while (sh < 40 && (den >> sh) >= 64'h1_0000_0000) sh++;
      num = num >> sh;
      den = den >> sh;
      w = longint'((num << 16) / den);
      sw += w;
      sb += st_second[k] * w;
      if (m_vec) sa += st_first[k] * w;
    end
    res.no_cov = (sw == 0);
    res.first = (sw != 0 && m_vec) ? 32'(sa / sw) : 32'd0;
    res.second = (sw != 0) ? 32'(sb / sw) : 32'd0;
    res.hits = 9'(hc);
    res.dropped = st_overflow;
    return res;
  endfunction

  task automatic apply_station_op(station_op_t it);
    if (it.op == 1'b0) begin
      if (it.restart) begin
        st_count = 0;
        st_overflow = 0;
      end
      if (st_count < TABLE_DEPTH) begin
        st_lon[st_count] = longint'($signed(it.lon));
        st_lat[st_count] = longint'($signed(it.lat));
        st_first[st_count] = longint'($signed(it.first));
        st_second[st_count] = longint'($signed(it.second));
        st_count++;
      end else begin
        st_overflow = 1;
      end
    end else begin
      expected_grid.insert(expected_grid.size(), evaluate_point(it.row, it.col));
    end
  endtask

  task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    case (idx)
      REG_VECTOR_MODE: m_vec = d[0];
      REG_RADIUS:      m_radius = d[30:0];
      REG_ORIGIN_LON:  m_olon = d;
      REG_ORIGIN_LAT:  m_olat = d;
      REG_LON_STEP:    m_lstep = d;
      REG_LAT_STEP:    m_tstep = d;
      default: ;
    endcase
  endtask

  // driver: present the next station operation after each transfer or gap
  always @(negedge clk) begin
    station_op_t it;
    if (rst) begin
      start <= 1'b0;
      gap <= 0;
    end else if (!start || took) begin
      if (gap != 0) begin
        start <= 1'b0;
        gap <= gap - 1;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].drain && expected_grid.size() != 0)) begin
        it = pending_ops.pop_front();
        op <= it.op;
        restart <= it.restart;
        station_lon <= it.lon;
        station_lat <= it.lat;
        sample_first <= it.first;
        sample_second <= it.second;
        row_index <= it.row;
        col_index <= it.col;
        start <= 1'b1;
        gap <= ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on each transfer, check each strobed grid value
  always @(posedge clk) begin
    station_op_t it;
    grid_value_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL scattered_to_grid_weighted_average_top");
      $finish;
    end
    took <= !rst && start && !busy;
    if (!rst && cfg_valid && cfg_ready) begin
      apply_register(cfg_index, cfg_data);
      cfg_count <= cfg_count + 1;
    end
    if (!rst && done) begin
      if (expected_grid.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected grid value at cycle %0d", cycles);
      end else begin
        want = expected_grid.pop_front();
        if (grid_first !== want.first || grid_second !== want.second ||
            hits !== want.hits || no_coverage !== want.no_cov ||
            stations_dropped !== want.dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %0d %b %b got %h %h %0d %b %b", want.first,
                     want.second, want.hits, want.no_cov, want.dropped, grid_first,
                     grid_second, hits, no_coverage, stations_dropped);
        end
      end
    end
    if (!rst && start && !busy) begin
      it.op = op; it.restart = restart;
      it.lon = station_lon; it.lat = station_lat;
      it.first = sample_first; it.second = sample_second;
      it.row = row_index; it.col = col_index; it.drain = 0;
      apply_station_op(it);
    end
  end

  function automatic station_op_t load_op(bit rs, logic [31:0] lon, logic [31:0] lat,
                                          logic [31:0] a, logic [31:0] b);
    station_op_t it;
    it = '{op: 1'b0, restart: rs, lon: lon, lat: lat, first: a, second: b,
           row: 10'($urandom), col: 10'($urandom), drain: 0};
    return it;
  endfunction

  function automatic station_op_t eval_op(logic [9:0] row, logic [9:0] col);
    station_op_t it;
    it = '{op: 1'b1, restart: 1'($urandom), lon: $urandom, lat: $urandom,
           first: $urandom, second: $urandom, row: row, col: col, drain: 0};
    return it;
  endfunction

  // evaluations and stations, mostly around the first grid points, some stations pure noise
  function automatic station_op_t random_op(bit restarts);
    station_op_t it;
    int unsigned span, c, r;
    span = (m_radius > 31'd1000000) ? 32'd2000000 : 2 * m_radius + 2;
    c = $urandom_range(0, 12);
    r = $urandom_range(0, 12);
    if ($urandom_range(0, 2) == 0) begin
      it = eval_op(($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'(r),
                   ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'(c));
    end else if ($urandom_range(0, 5) == 0) begin
      it = load_op(restarts && $urandom_range(0, 9) == 0, $urandom, $urandom, $urandom,
                   $urandom);
    end else begin
      it = load_op(restarts && $urandom_range(0, 15) == 0,
                   m_olon + m_lstep * c + $urandom_range(0, span) - span / 2,
                   m_olat + m_tstep * r + $urandom_range(0, span) - span / 2,
                   $signed($urandom) >>> $urandom_range(0, 12),
                   $signed($urandom) >>> $urandom_range(0, 12));
    end
    return it;
  endfunction

  task automatic wait_idle();
    wait (pending_ops.size() == 0);
    @(posedge clk);
    while (start || busy || expected_grid.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    int n0;
    n0 = cfg_count;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(negedge clk); while (cfg_count == n0);
  endtask

  task automatic set_grid(bit vec, logic [30:0] rad, logic [31:0] olon, logic [31:0] olat,
                          logic [31:0] lstep, logic [31:0] tstep);
    write_register(REG_VECTOR_MODE, {31'($urandom), vec});
    write_register(REG_RADIUS, {1'($urandom), rad});
    write_register(REG_ORIGIN_LON, olon);
    write_register(REG_ORIGIN_LAT, olat);
    write_register(REG_LON_STEP, lstep);
    write_register(REG_LAT_STEP, tstep);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    station_op_t it;
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part on reset settings
    queue_op(eval_op(10'd0, 10'd0));
    queue_op(load_op(1, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000));
    queue_op(load_op(0, 32'd3277, 32'd0, 32'hFFFF_FFFF, 32'd327680));
    queue_op(load_op(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF));
    queue_op(load_op(0, 32'd65536, 32'd0, 32'd100, 32'd200));
    queue_op(load_op(0, 32'd46341, 32'd46341, 32'd7, 32'd9));
    queue_op(eval_op(10'd0, 10'd0));
    queue_op(eval_op(10'd0, 10'd1));
    queue_op(eval_op(10'd0, 10'd20));
    queue_op(eval_op(10'd14, 10'd14));
    queue_op(eval_op(10'd1023, 10'd1023));
    it = eval_op(10'd0, 10'd2);
    it.drain = 1;
    queue_op(it);
    queue_op(load_op(1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_0000));
    queue_op(eval_op(10'd0, 10'd0));
    wait_idle();

    // zero radius, then the largest radius at the coordinate extremes
    set_grid(1, 31'd0, 32'd0, 32'd0, 32'd3277, 32'd3277);
    queue_op(eval_op(10'd0, 10'd0));
    queue_op(load_op(0, 32'd0, 32'd0, 32'd1, 32'd1));
    queue_op(eval_op(10'd0, 10'd0));
    wait_idle();
    set_grid(1, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_op(load_op(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    queue_op(load_op(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    queue_op(eval_op(10'd0, 10'd0));
    queue_op(eval_op(10'd1, 10'd1));
    queue_op(eval_op(10'd1023, 10'd0));
    for (int i = 0; i < 12; i++) queue_op(random_op(1));
    wait_idle();

    // random phases with random grid settings, small tables
    for (int ph = 0; ph < 3; ph++) begin
      set_grid($urandom, 31'($urandom_range(20000, 400000)), $urandom, $urandom,
               $signed(32'($urandom_range(0, 200000))) - 100000,
               $signed(32'($urandom_range(0, 200000))) - 100000);
      queue_op(load_op(1, m_olon, m_olat, $urandom, $urandom));
      for (int i = 0; i < 14; i++) queue_op(random_op(1));
      it = eval_op(10'd0, 10'd0);
      it.drain = 1;
      queue_op(it);
      for (int i = 0; i < 3; i++) queue_op(random_op(1));
      wait_idle();
    end

    // fill past capacity, then clear the dropped flag with a restart
    set_grid(0, 31'd65536, 32'd0, 32'd0, 32'd3277, 32'd3277);
    queue_op(load_op(1, 32'd0, 32'd0, 32'd5, 32'd6));
    for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
      it = random_op(0);
      it.op = 1'b0;
      queue_op(it);
    end
    queue_op(eval_op(10'd0, 10'd0));
    queue_op(eval_op(10'd3, 10'd5));
    queue_op(load_op(1, 32'd10, 32'd10, 32'd1, 32'd2));
    queue_op(eval_op(10'd0, 10'd0));
    wait_idle();

    if (mismatches == 0 && expected_grid.size() == 0) begin
      $display("PASS scattered_to_grid_weighted_average_top");
    end else begin
      $display("FAIL scattered_to_grid_weighted_average_top");
    end
    $finish;
  end
endmodule
